// File: rtl/odr_pkg.sv
// Shared types, constants and tables for the odometry dead-reckoning core.
// No dependencies; used by the interfaces, controller, datapath and top level.
package odr_pkg;

  // Default number of CORDIC iterations (at most 32, the arctangent table depth)
  localparam int unsigned CORDIC_STEPS_DEF = 14;

  // Arctangent table depth and index width
  localparam int unsigned ATAN_DEPTH = 32;
  localparam int unsigned ATAN_IDX_W = 5;

  // CORDIC vector and angle width (Q2.30 / 2^31 = pi, plus guard bits)
  localparam int unsigned CW = 34;

  localparam logic signed [CW-1:0] INV_GAIN     = 34'sd652032874;
  localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;

  // atan(2^-k) in units where 2^31 = pi
  localparam logic signed [CW-1:0] ATAN_TAB [ATAN_DEPTH] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81,
    34'sd41,        34'sd20,        34'sd10,        34'sd5,
    34'sd3,         34'sd1,         34'sd1,         34'sd0
  };

  // Field widths
  localparam int unsigned IN_W   = 16;
  localparam int unsigned POS_W  = 48;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned PROD_W = 52;
  localparam int unsigned MB_W   = 18;
  localparam int unsigned NRG_W  = 32;

  // Rounding bias added before the >>> 31 that lands the delta in Q.28
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = 64'sd1073741824;

  // Configuration register map
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SAMPLES  = 3'd4;

  localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd328;
  localparam logic [31:0] RST_WHEEL_LIMIT   = 32'd17;
  localparam logic [31:0] RST_GYRO_LIMIT    = 32'd12582912;
  localparam logic [31:0] RST_TILT_LIMIT    = 32'd828100;
  localparam logic [15:0] RST_HOLD_SAMPLES  = 16'd100;

  // Multiplier operand selection
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_LL,
    MUL_RR,
    MUL_GX,
    MUL_GY,
    MUL_GZ,
    MUL_PA,
    MUL_RA,
    MUL_SP,
    MUL_C_LO,
    MUL_C_HI,
    MUL_S_LO,
    MUL_S_HI
  } mul_sel_e;

  // What to do with last cycle's product
  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_WHEEL_SET,
    ACC_WHEEL_ADD,
    ACC_GYRO_SET,
    ACC_GYRO_ADD,
    ACC_TILT_SET,
    ACC_TILT_ADD,
    ACC_T1,
    ACC_N_SET,
    ACC_N_ADD,
    ACC_E_SET,
    ACC_E_ADD
  } acc_sel_e;

  typedef struct packed {
    logic                  load;
    logic                  rot;
    logic [ATAN_IDX_W-1:0] rot_idx;
    logic                  flip_fix;
    mul_sel_e              mul_sel;
    acc_sel_e              acc_sel;
    logic                  commit;
  } odr_cmd_t;

  typedef struct packed {
    logic signed [IN_W-1:0] left_speed;
    logic signed [IN_W-1:0] right_speed;
    logic signed [IN_W-1:0] heading;
    logic signed [IN_W-1:0] pitch_angle;
    logic signed [IN_W-1:0] roll_angle;
    logic signed [IN_W-1:0] rate_x;
    logic signed [IN_W-1:0] rate_y;
    logic signed [IN_W-1:0] rate_z;
  } odr_sample_t;

endpackage

// File: rtl/odr_if.sv
// Handshake interfaces for the sample input, result output and config write channels.
// Depends on odr_pkg for field widths.
interface odr_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [odr_pkg::IN_W-1:0]  left_speed;
  logic signed [odr_pkg::IN_W-1:0]  right_speed;
  logic signed [odr_pkg::IN_W-1:0]  heading;
  logic signed [odr_pkg::IN_W-1:0]  pitch_angle;
  logic signed [odr_pkg::IN_W-1:0]  roll_angle;
  logic signed [odr_pkg::IN_W-1:0]  rate_x;
  logic signed [odr_pkg::IN_W-1:0]  rate_y;
  logic signed [odr_pkg::IN_W-1:0]  rate_z;

  modport source (
    output valid, left_speed, right_speed, heading, pitch_angle, roll_angle,
           rate_x, rate_y, rate_z,
    input  ready
  );
  modport sink (
    input  valid, left_speed, right_speed, heading, pitch_angle, roll_angle,
           rate_x, rate_y, rate_z,
    output ready
  );
endinterface

interface odr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [odr_pkg::POS_W-1:0]  north_position;
  logic signed [odr_pkg::POS_W-1:0]  east_position;
  logic                              standstill;
  logic                              tilted;

  modport source (
    output valid, north_position, east_position, standstill, tilted,
    input  ready
  );
  modport sink (
    input  valid, north_position, east_position, standstill, tilted,
    output ready
  );
endinterface

interface odr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [odr_pkg::CFG_IDX_W-1:0]     index;
  logic [odr_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/odometry_dead_reckoning_step_core.sv
// Top level of the odometry dead-reckoning core: controller plus datapath.
// Depends on odr_pkg, the odr_*_if interfaces, odr_ctrl and odr_dp.

// One sample is taken at a time and occupies the core from acceptance to
// the next acceptance: the accept step, CORDIC_STEPS iterations of the shared
// shift-add CORDIC unit, a schedule in which a single 34x18 multiplier is
// reused for the squared energies, the speed-times-period product and the two
// halves of each position delta, and a commit step that waits until the
// output register is free. The result then sits in the output register; a
// new sample can be accepted while it waits, but the next result is held
// back until it is taken. Positions are Q20.28 and wrap at 48 bits. Config
// registers are written through cfg_i (always ready) and must only change
// while idle.
module odometry_dead_reckoning_step_core #(
  parameter int unsigned CORDIC_STEPS = odr_pkg::CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  odr_in_if.sink    in_i,
  odr_out_if.source out_o,
  odr_cfg_if.sink   cfg_i
);

  odr_pkg::odr_cmd_t    cmd;
  odr_pkg::odr_sample_t sample;
  logic                 in_ready;
  logic                 out_valid;

  assign sample.left_speed  = in_i.left_speed;
  assign sample.right_speed = in_i.right_speed;
  assign sample.heading     = in_i.heading;
  assign sample.pitch_angle = in_i.pitch_angle;
  assign sample.roll_angle  = in_i.roll_angle;
  assign sample.rate_x      = in_i.rate_x;
  assign sample.rate_y      = in_i.rate_y;
  assign sample.rate_z      = in_i.rate_z;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign cfg_i.ready = 1'b1;

  odr_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  odr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sample_i     (sample),
    .cfg_we_i     (cfg_i.valid),
    .cfg_idx_i    (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .north_o      (out_o.north_position),
    .east_o       (out_o.east_position),
    .standstill_o (out_o.standstill),
    .tilted_o     (out_o.tilted)
  );

endmodule

// File: rtl/odr_ctrl.sv
// Controller: sequences CORDIC iterations, the shared multiplier schedule and commit.
// Depends on odr_pkg for the command struct and selection enums.
module odr_ctrl #(
  parameter int unsigned CORDIC_STEPS = odr_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output odr_pkg::odr_cmd_t cmd_o
);

  localparam int unsigned CNT_W =
    ($clog2(CORDIC_STEPS) > 4) ? $clog2(CORDIC_STEPS) : 4;
  localparam int unsigned POST_LAST = 14;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROT  = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             can_commit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign can_commit  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ROT;
          cnt_d      = '0;
        end
      end
      ST_ROT: begin
        cmd_o.rot     = 1'b1;
        cmd_o.rot_idx = odr_pkg::ATAN_IDX_W'(cnt_q);
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          state_d = ST_POST;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_POST: begin
        // multiply issued this cycle, its product consumed in the next cycle
        unique case (cnt_q)
          0: begin
            cmd_o.mul_sel  = odr_pkg::MUL_LL;
            cmd_o.flip_fix = 1'b1;
          end
          1: begin
            cmd_o.mul_sel = odr_pkg::MUL_RR;
            cmd_o.acc_sel = odr_pkg::ACC_WHEEL_SET;
          end
          2: begin
            cmd_o.mul_sel = odr_pkg::MUL_GX;
            cmd_o.acc_sel = odr_pkg::ACC_WHEEL_ADD;
          end
          3: begin
            cmd_o.mul_sel = odr_pkg::MUL_GY;
            cmd_o.acc_sel = odr_pkg::ACC_GYRO_SET;
          end
          4: begin
            cmd_o.mul_sel = odr_pkg::MUL_GZ;
            cmd_o.acc_sel = odr_pkg::ACC_GYRO_ADD;
          end
          5: begin
            cmd_o.mul_sel = odr_pkg::MUL_PA;
            cmd_o.acc_sel = odr_pkg::ACC_GYRO_ADD;
          end
          6: begin
            cmd_o.mul_sel = odr_pkg::MUL_RA;
            cmd_o.acc_sel = odr_pkg::ACC_TILT_SET;
          end
          7: begin
            cmd_o.mul_sel = odr_pkg::MUL_SP;
            cmd_o.acc_sel = odr_pkg::ACC_TILT_ADD;
          end
          8: begin
            cmd_o.acc_sel = odr_pkg::ACC_T1;
          end
          9: begin
            cmd_o.mul_sel = odr_pkg::MUL_C_LO;
          end
          10: begin
            cmd_o.mul_sel = odr_pkg::MUL_C_HI;
            cmd_o.acc_sel = odr_pkg::ACC_N_SET;
          end
          11: begin
            cmd_o.mul_sel = odr_pkg::MUL_S_LO;
            cmd_o.acc_sel = odr_pkg::ACC_N_ADD;
          end
          12: begin
            cmd_o.mul_sel = odr_pkg::MUL_S_HI;
            cmd_o.acc_sel = odr_pkg::ACC_E_SET;
          end
          13: begin
            cmd_o.acc_sel = odr_pkg::ACC_E_ADD;
          end
          default: begin
            // final step: waits here until the output register is free
            if (can_commit) begin
              cmd_o.commit = 1'b1;
              state_d      = ST_IDLE;
            end
          end
        endcase
        if (cnt_q != CNT_W'(POST_LAST)) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/odr_dp.sv
// Datapath: config registers, iterative CORDIC, shared multiplier, position and
// standstill state. Depends on odr_pkg; driven by commands from odr_ctrl.
module odr_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  odr_pkg::odr_cmd_t                   cmd_i,
  input  odr_pkg::odr_sample_t                sample_i,
  input  logic                                cfg_we_i,
  input  logic [odr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [odr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic signed [odr_pkg::POS_W-1:0]    north_o,
  output logic signed [odr_pkg::POS_W-1:0]    east_o,
  output logic                                standstill_o,
  output logic                                tilted_o
);

  localparam int unsigned CW    = odr_pkg::CW;
  localparam int unsigned ACC_W = odr_pkg::ACC_W;
  localparam int unsigned POS_W = odr_pkg::POS_W;
  localparam int unsigned NRG_W = odr_pkg::NRG_W;
  localparam int unsigned MB_W  = odr_pkg::MB_W;

  // config registers
  logic [15:0] sample_period_q;
  logic [31:0] wheel_limit_q;
  logic [31:0] gyro_limit_q;
  logic [31:0] tilt_limit_q;
  logic [15:0] hold_samples_q;

  // payload registers
  odr_pkg::odr_sample_t                smp_q;
  logic signed [CW-1:0]                x_q, y_q, z_q;
  logic                                flip_q;
  logic signed [odr_pkg::PROD_W-1:0]   prod_q;
  logic signed [CW-1:0]                t1_q;
  logic [NRG_W-1:0]                    wheel_e_q, gyro_e_q, tilt_e_q;
  logic signed [ACC_W-1:0]             dn_q, de_q;

  // state
  logic signed [POS_W-1:0] pos_n_q, pos_e_q;
  logic [15:0]             quiet_cnt_q, quiet_cnt_d;
  logic                    quiet_run_q, quiet_run_d;
  logic                    still_q, still_d;
  logic                    tilt_q;

  // CORDIC helpers
  logic signed [CW-1:0] z0, z_init;
  logic                 flip_init;
  logic signed [CW-1:0] dx, dy, atan_k;

  // multiplier
  logic signed [CW-1:0]               mul_a;
  logic signed [MB_W-1:0]             mul_b;
  logic signed [odr_pkg::PROD_W-1:0]  mul_p;
  logic [NRG_W-1:0]                   prod_lo;
  logic signed [ACC_W-1:0]            prod_ext;

  // commit
  logic        quiet, tilt_now;
  logic [15:0] cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_period_q <= odr_pkg::RST_SAMPLE_PERIOD;
      wheel_limit_q   <= odr_pkg::RST_WHEEL_LIMIT;
      gyro_limit_q    <= odr_pkg::RST_GYRO_LIMIT;
      tilt_limit_q    <= odr_pkg::RST_TILT_LIMIT;
      hold_samples_q  <= odr_pkg::RST_HOLD_SAMPLES;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        odr_pkg::CFG_SAMPLE_PERIOD: sample_period_q <= cfg_data_i[15:0];
        odr_pkg::CFG_WHEEL_LIMIT:   wheel_limit_q   <= cfg_data_i;
        odr_pkg::CFG_GYRO_LIMIT:    gyro_limit_q    <= cfg_data_i;
        odr_pkg::CFG_TILT_LIMIT:    tilt_limit_q    <= cfg_data_i;
        odr_pkg::CFG_HOLD_SAMPLES:  hold_samples_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // heading as a 32-bit binary angle, folded into [-pi/2, pi/2]
  always_comb begin
    z0        = CW'($signed({sample_i.heading, 16'h0000}));
    z_init    = z0;
    flip_init = 1'b0;
    if (z0 > odr_pkg::QUARTER_TURN) begin
      z_init    = z0 - odr_pkg::HALF_TURN;
      flip_init = 1'b1;
    end else if (z0 < -odr_pkg::QUARTER_TURN) begin
      z_init    = z0 + odr_pkg::HALF_TURN;
      flip_init = 1'b1;
    end
  end

  assign dx     = y_q >>> cmd_i.rot_idx;
  assign dy     = x_q >>> cmd_i.rot_idx;
  assign atan_k = odr_pkg::ATAN_TAB[cmd_i.rot_idx];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      odr_pkg::MUL_LL: begin
        mul_a = CW'(smp_q.left_speed);
        mul_b = MB_W'(smp_q.left_speed);
      end
      odr_pkg::MUL_RR: begin
        mul_a = CW'(smp_q.right_speed);
        mul_b = MB_W'(smp_q.right_speed);
      end
      odr_pkg::MUL_GX: begin
        mul_a = CW'(smp_q.rate_x);
        mul_b = MB_W'(smp_q.rate_x);
      end
      odr_pkg::MUL_GY: begin
        mul_a = CW'(smp_q.rate_y);
        mul_b = MB_W'(smp_q.rate_y);
      end
      odr_pkg::MUL_GZ: begin
        mul_a = CW'(smp_q.rate_z);
        mul_b = MB_W'(smp_q.rate_z);
      end
      odr_pkg::MUL_PA: begin
        mul_a = CW'(smp_q.pitch_angle);
        mul_b = MB_W'(smp_q.pitch_angle);
      end
      odr_pkg::MUL_RA: begin
        mul_a = CW'(smp_q.roll_angle);
        mul_b = MB_W'(smp_q.roll_angle);
      end
      odr_pkg::MUL_SP: begin
        // L + R read as Q4.13, times the period
        mul_a = CW'(smp_q.left_speed) + CW'(smp_q.right_speed);
        mul_b = $signed({2'b00, sample_period_q});
      end
      odr_pkg::MUL_C_LO: begin
        mul_a = x_q;
        mul_b = $signed({2'b00, t1_q[15:0]});
      end
      odr_pkg::MUL_C_HI: begin
        mul_a = x_q;
        mul_b = $signed(t1_q[CW-1:16]);
      end
      odr_pkg::MUL_S_LO: begin
        mul_a = y_q;
        mul_b = $signed({2'b00, t1_q[15:0]});
      end
      odr_pkg::MUL_S_HI: begin
        mul_a = y_q;
        mul_b = $signed(t1_q[CW-1:16]);
      end
      default: ;
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_lo  = prod_q[NRG_W-1:0];
  assign prod_ext = ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (cmd_i.load) begin
      smp_q  <= sample_i;
      x_q    <= odr_pkg::INV_GAIN;
      y_q    <= '0;
      z_q    <= z_init;
      flip_q <= flip_init;
    end else if (cmd_i.rot) begin
      if (!z_q[CW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_k;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_k;
      end
    end else if (cmd_i.flip_fix && flip_q) begin
      x_q <= -x_q;
      y_q <= -y_q;
    end

    unique case (cmd_i.acc_sel)
      odr_pkg::ACC_WHEEL_SET: wheel_e_q <= prod_lo;
      odr_pkg::ACC_WHEEL_ADD: wheel_e_q <= wheel_e_q + prod_lo;
      odr_pkg::ACC_GYRO_SET:  gyro_e_q  <= prod_lo;
      odr_pkg::ACC_GYRO_ADD:  gyro_e_q  <= gyro_e_q + prod_lo;
      odr_pkg::ACC_TILT_SET:  tilt_e_q  <= prod_lo;
      odr_pkg::ACC_TILT_ADD:  tilt_e_q  <= tilt_e_q + prod_lo;
      odr_pkg::ACC_T1:        t1_q      <= prod_q[CW-1:0];
      odr_pkg::ACC_N_SET:     dn_q      <= prod_ext + odr_pkg::ROUND_BIAS;
      odr_pkg::ACC_N_ADD:     dn_q      <= dn_q + (prod_ext <<< 16);
      odr_pkg::ACC_E_SET:     de_q      <= prod_ext + odr_pkg::ROUND_BIAS;
      odr_pkg::ACC_E_ADD:     de_q      <= de_q + (prod_ext <<< 16);
      default: ;
    endcase
  end

  // standstill run tracking
  always_comb begin
    quiet       = (wheel_e_q < wheel_limit_q) && (gyro_e_q < gyro_limit_q);
    tilt_now    = !(tilt_e_q < tilt_limit_q);
    cnt_inc     = (quiet_cnt_q != 16'hFFFF) ? quiet_cnt_q + 16'd1 : quiet_cnt_q;
    quiet_run_d = quiet_run_q;
    quiet_cnt_d = quiet_cnt_q;
    still_d     = still_q;
    if (!quiet) begin
      quiet_run_d = 1'b0;
      quiet_cnt_d = '0;
      still_d     = 1'b0;
    end else if (!quiet_run_q) begin
      quiet_run_d = 1'b1;
      quiet_cnt_d = '0;
    end else begin
      quiet_cnt_d = cnt_inc;
      if (cnt_inc > hold_samples_q) begin
        still_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_n_q     <= '0;
      pos_e_q     <= '0;
      quiet_cnt_q <= '0;
      quiet_run_q <= 1'b0;
      still_q     <= 1'b0;
      tilt_q      <= 1'b0;
    end else if (cmd_i.commit) begin
      // delta is the accumulator >>> 31, sign-extended into the 48-bit wrap
      pos_n_q     <= pos_n_q + POS_W'($signed(dn_q[ACC_W-1:31]));
      pos_e_q     <= pos_e_q + POS_W'($signed(de_q[ACC_W-1:31]));
      quiet_cnt_q <= quiet_cnt_d;
      quiet_run_q <= quiet_run_d;
      still_q     <= still_d;
      tilt_q      <= tilt_now;
    end
  end

  assign north_o      = pos_n_q;
  assign east_o       = pos_e_q;
  assign standstill_o = still_q;
  assign tilted_o     = tilt_q;

endmodule

// File: rtl/odr_checker.sv
// Port-level checker for the odometry core, bound to the top level.
// Depends on odr_pkg for widths, the top-level ports and the CORDIC_STEPS parameter.
module odr_checker #(
  parameter int unsigned CORDIC_STEPS = odr_pkg::CORDIC_STEPS_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [odr_pkg::POS_W-1:0]   north_i,
  input logic signed [odr_pkg::POS_W-1:0]   east_i,
  input logic                               standstill_i,
  input logic                               tilted_i
);

  // core is busy right after taking a sample
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i
  ) else $error("input ready high right after a transaction");

  // a result is on the output at the end of the schedule for an accepted sample
  a_result_latency: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |-> ##(CORDIC_STEPS + 16) out_valid_i
  ) else $error("no result after the processing window");

  // no new sample is taken in the final step of the previous sample's schedule
  a_no_overlap: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |-> ##(CORDIC_STEPS + 15) !in_ready_i
  ) else $error("input ready before the schedule completed");

  // stalled result holds its payload
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(north_i) && $stable(east_i) &&
       $stable(standstill_i) && $stable(tilted_i))
  ) else $error("output transaction changed while stalled");

endmodule

bind odometry_dead_reckoning_step_core odr_checker #(
  .CORDIC_STEPS (CORDIC_STEPS)
) u_odr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .north_i      (out_o.north_position),
  .east_i       (out_o.east_position),
  .standstill_i (out_o.standstill),
  .tilted_i     (out_o.tilted)
);
